[hw/rtl/edd_pkg.sv]
// Shared types and constants of the error diffusion dither block.
// Used by the controller, the datapath and the top level; depends on nothing.

package edd_pkg;

    localparam int NCH        = 3;   // color channels, red in lane 0
    localparam int PIX_W      = 8;
    localparam int ERR_W      = 9;   // two's complement error per channel
    localparam int ERR_PACK_W = NCH * ERR_W;
    localparam int ROW_W      = 13;
    localparam int CFG_DATA_W = 13;
    localparam int CFG_IDX_W  = 2;
    localparam int MAX_HEIGHT = 4096;

    localparam logic [CFG_IDX_W-1:0] CFG_LEVELS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 2'd2;

    localparam logic [PIX_W-1:0]      LEVELS_RESET = 8'd4;
    localparam logic [CFG_DATA_W-1:0] WIDTH_RESET  = 13'd640;
    localparam logic [CFG_DATA_W-1:0] HEIGHT_RESET = 13'd480;

    // Floyd-Steinberg weights in sixteenths.
    localparam logic [2:0] WT_UPPER_LEFT  = 3'd1;
    localparam logic [2:0] WT_UPPER       = 3'd5;
    localparam logic [2:0] WT_UPPER_RIGHT = 3'd3;
    localparam logic [2:0] WT_LEFT        = 3'd7;

    typedef struct packed {
        logic accept;
        logic add_ul;
        logic add_up;
        logic add_ur;
        logic add_left;
        logic mul1;
        logic mul2;
        logic quant;
        logic commit;
    } edd_cmd_t;

    typedef struct packed {
        logic out_free;
    } edd_sts_t;

endpackage

[hw/rtl/edd_ram.sv]
// Generic single write port RAM with two registered read ports.
// Stand-alone; no package needed.

module edd_ram #(
    parameter int WIDTH = 27,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr_a,
    input  logic [$clog2(DEPTH)-1:0] raddr_b,
    output logic [WIDTH-1:0]         rdata_a,
    output logic [WIDTH-1:0]         rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_a <= mem[raddr_a];
            rdata_b <= mem[raddr_b];
        end
    end

endmodule

[hw/rtl/edd_ctrl.sv]
// Sequencer of the dither block: walks one pixel through the datapath steps.
// Depends on edd_pkg for the command and status structs.

module edd_ctrl import edd_pkg::*; (
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    input  edd_sts_t sts,
    output edd_cmd_t cmd
);

    typedef enum logic [8:0] {
        S_IDLE  = 9'b000000001,
        S_UL    = 9'b000000010,
        S_UP    = 9'b000000100,
        S_UR    = 9'b000001000,
        S_LEFT  = 9'b000010000,
        S_MUL1  = 9'b000100000,
        S_MUL2  = 9'b001000000,
        S_QUANT = 9'b010000000,
        S_WB    = 9'b100000000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready   = 1'b1;
                cmd.accept = in_valid;
                if (in_valid)
                begin
                    state_next = S_UL;
                end
            end
            S_UL:
            begin
                cmd.add_ul = 1'b1;
                state_next = S_UP;
            end
            S_UP:
            begin
                cmd.add_up = 1'b1;
                state_next = S_UR;
            end
            S_UR:
            begin
                cmd.add_ur = 1'b1;
                state_next = S_LEFT;
            end
            S_LEFT:
            begin
                cmd.add_left = 1'b1;
                state_next   = S_MUL1;
            end
            S_MUL1:
            begin
                cmd.mul1   = 1'b1;
                state_next = S_MUL2;
            end
            S_MUL2:
            begin
                cmd.mul2   = 1'b1;
                state_next = S_QUANT;
            end
            S_QUANT:
            begin
                cmd.quant  = 1'b1;
                state_next = S_WB;
            end
            S_WB:
            begin
                // The result waits here until the output register is free.
                cmd.commit = sts.out_free;
                if (sts.out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> (state_reg == S_UL))
        else $error("accepted pixel did not start the sequence");

    a_wb_release: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_WB && sts.out_free) |=> (state_reg == S_IDLE))
        else $error("write back did not return to idle");

    a_state_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot(state_reg))
        else $error("sequencer state is not one-hot");

endmodule

[hw/rtl/edd_datapath.sv]
// Datapath of the dither block: config registers, raster counters, error
// line store, per-channel error adds and quantizer. Depends on edd_pkg, edd_ram.

module edd_datapath import edd_pkg::*; #(
    parameter int MAX_WIDTH = 4096
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [CFG_IDX_W-1:0]            cfg_index,
    input  logic [CFG_DATA_W-1:0]           cfg_data,
    input  logic [NCH-1:0][PIX_W-1:0]       pix_in,
    input  logic                            out_ready,
    input  edd_cmd_t                        cmd,
    output edd_sts_t                        sts,
    output logic                            out_valid,
    output logic [NCH-1:0][PIX_W-1:0]       pix_out,
    output logic                            frame_end
);

    localparam int AW = $clog2(MAX_WIDTH);
    localparam int CW = AW + 1;
    localparam int EW = (CW > CFG_DATA_W) ? CW : CFG_DATA_W;

    typedef struct packed {
        logic [PIX_W-1:0] step;
        logic [16:0]      recip;
    } step_pair_t;

    // step = 255 / levels, recip = ceil(65536 / step); a zero level count acts as one.
    function automatic step_pair_t step_entry(input logic [PIX_W-1:0] lv);
        step_pair_t p;
        case (lv) inside
            8'd0, 8'd1:     p = '{8'd255, 17'd258};
            8'd2:           p = '{8'd127, 17'd517};
            8'd3:           p = '{8'd85,  17'd772};
            8'd4:           p = '{8'd63,  17'd1041};
            8'd5:           p = '{8'd51,  17'd1286};
            8'd6:           p = '{8'd42,  17'd1561};
            8'd7:           p = '{8'd36,  17'd1821};
            8'd8:           p = '{8'd31,  17'd2115};
            8'd9:           p = '{8'd28,  17'd2341};
            8'd10:          p = '{8'd25,  17'd2622};
            8'd11:          p = '{8'd23,  17'd2850};
            8'd12:          p = '{8'd21,  17'd3121};
            8'd13:          p = '{8'd19,  17'd3450};
            8'd14:          p = '{8'd18,  17'd3641};
            8'd15:          p = '{8'd17,  17'd3856};
            [8'd16:8'd17]:  p = '{8'd15,  17'd4370};
            [8'd18:8'd18]:  p = '{8'd14,  17'd4682};
            [8'd19:8'd19]:  p = '{8'd13,  17'd5042};
            [8'd20:8'd21]:  p = '{8'd12,  17'd5462};
            [8'd22:8'd23]:  p = '{8'd11,  17'd5958};
            [8'd24:8'd25]:  p = '{8'd10,  17'd6554};
            [8'd26:8'd28]:  p = '{8'd9,   17'd7282};
            [8'd29:8'd31]:  p = '{8'd8,   17'd8192};
            [8'd32:8'd36]:  p = '{8'd7,   17'd9363};
            [8'd37:8'd42]:  p = '{8'd6,   17'd10923};
            [8'd43:8'd51]:  p = '{8'd5,   17'd13108};
            [8'd52:8'd63]:  p = '{8'd4,   17'd16384};
            [8'd64:8'd85]:  p = '{8'd3,   17'd21846};
            [8'd86:8'd127]: p = '{8'd2,   17'd32768};
            default:        p = '{8'd1,   17'd65536};
        endcase
        return p;
    endfunction

    // v + e*w/16 truncated toward zero, then clamped to 0..255.
    function automatic logic [PIX_W-1:0] add_part(input logic [PIX_W-1:0] v,
                                                  input logic signed [ERR_W-1:0] e,
                                                  input logic [2:0] w);
        logic signed [14:0] ew;
        logic signed [14:0] wx;
        logic signed [14:0] s;
        logic [PIX_W-1:0]   res;
        ew = e;
        wx = $signed({12'b0, w});
        s  = $signed({3'b0, v, 4'b0}) + ew * wx;
        if (s < 0)
        begin
            res = '0;
        end
        else if (s[14:4] > 11'd255)
        begin
            res = 8'd255;
        end
        else
        begin
            res = s[11:4];
        end
        return res;
    endfunction

    // Configuration and carried state.
    logic [PIX_W-1:0]      levels_reg;
    logic [CFG_DATA_W-1:0] width_reg;
    logic [CFG_DATA_W-1:0] height_reg;
    logic [CW-1:0]         col_reg;
    logic [ROW_W-1:0]      row_reg;
    logic [ERR_PACK_W-1:0] left_reg;
    logic [ERR_PACK_W-1:0] ul_reg;
    logic                  out_valid_reg;

    // Per-pixel working registers.
    logic [NCH-1:0][PIX_W-1:0]       v_reg;
    logic [NCH-1:0][PIX_W-1:0]       q_reg;
    logic [NCH-1:0][PIX_W-1:0]       qstep_reg;
    logic [NCH-1:0]                  qtop_reg;
    logic [NCH-1:0][PIX_W-1:0]       qout_reg;
    logic [NCH-1:0][ERR_W-1:0]       err_reg;
    logic [NCH-1:0][PIX_W-1:0]       pix_out_reg;
    logic                            frame_end_reg;
    logic [CW-1:0]                   x_reg;
    logic [ROW_W-1:0]                y_reg;

    // Quantizer constants are registered from the levels register; the top level is registered again from them.
    step_pair_t       step_pair;
    logic [PIX_W-1:0] step_reg;
    logic [16:0]      recip_reg;
    logic [PIX_W-1:0] lvm1_reg;
    logic [PIX_W-1:0] top_reg;

    logic [PIX_W-1:0]      lv_eff;
    logic [EW-1:0]         w_sat;
    logic [CW-1:0]         w_eff;
    logic [ROW_W-1:0]      h_eff;
    logic                  wrap_col;
    logic [ROW_W-1:0]      row_tmp;
    logic [CW-1:0]         x_norm;
    logic [ROW_W-1:0]      y_norm;
    logic [CW-1:0]         x_inc;
    logic [ROW_W-1:0]      y_inc;
    logic                  has_left;
    logic                  has_up;
    logic                  has_ur;
    logic [ERR_PACK_W-1:0] rdata_a;
    logic [ERR_PACK_W-1:0] rdata_b;
    logic [ERR_PACK_W-1:0] add_word;
    logic [2:0]            add_wt;
    logic                  add_en;
    logic [15:0]           top_prod;
    logic [NCH-1:0][24:0]  recip_prod;
    logic [NCH-1:0][15:0]  qstep_prod;
    logic [NCH-1:0][PIX_W-1:0] rem;
    logic [NCH-1:0][PIX_W-1:0] qout_next;

    assign lv_eff    = (levels_reg == '0) ? 8'd1 : levels_reg;
    assign step_pair = step_entry(lv_eff);

    always_comb
    begin
        w_sat = (width_reg == '0) ? EW'(1) : EW'(width_reg);
        if (w_sat > EW'(MAX_WIDTH))
        begin
            w_sat = EW'(MAX_WIDTH);
        end
        w_eff = w_sat[CW-1:0];
        if (height_reg == '0)
        begin
            h_eff = ROW_W'(1);
        end
        else if (height_reg > ROW_W'(MAX_HEIGHT))
        begin
            h_eff = ROW_W'(MAX_HEIGHT);
        end
        else
        begin
            h_eff = height_reg;
        end
    end

    // A position left beyond a shrunken frame starts a new row or frame.
    assign wrap_col = (col_reg >= w_eff);
    assign x_norm   = wrap_col ? '0 : col_reg;
    assign row_tmp  = wrap_col ? row_reg + ROW_W'(1) : row_reg;
    assign y_norm   = (row_tmp >= h_eff) ? '0 : row_tmp;

    assign x_inc    = x_reg + CW'(1);
    assign y_inc    = y_reg + ROW_W'(1);
    assign has_left = (x_reg != '0);
    assign has_up   = (y_reg != '0);
    assign has_ur   = (x_inc < w_eff);

    // Which neighbor error is added this cycle.
    always_comb
    begin
        add_word = left_reg;
        add_wt   = WT_LEFT;
        add_en   = 1'b0;
        if (cmd.add_ul)
        begin
            add_word = ul_reg;
            add_wt   = WT_UPPER_LEFT;
            add_en   = has_up && has_left;
        end
        else if (cmd.add_up)
        begin
            add_word = rdata_a;
            add_wt   = WT_UPPER;
            add_en   = has_up;
        end
        else if (cmd.add_ur)
        begin
            add_word = rdata_b;
            add_wt   = WT_UPPER_RIGHT;
            add_en   = has_up && has_ur;
        end
        else if (cmd.add_left)
        begin
            add_word = left_reg;
            add_wt   = WT_LEFT;
            add_en   = has_left;
        end
    end

    assign top_prod = 16'(lvm1_reg) * 16'(step_reg);

    always_comb
    begin
        for (int c = 0; c < NCH; c++)
        begin
            recip_prod[c] = 25'(v_reg[c]) * 25'(recip_reg);
            qstep_prod[c] = 16'(q_reg[c]) * 16'(step_reg);
            rem[c]        = v_reg[c] - qstep_reg[c];
            if (qtop_reg[c])
            begin
                qout_next[c] = top_reg;
            end
            else if ({rem[c], 1'b0} > {1'b0, step_reg})
            begin
                qout_next[c] = qstep_reg[c] + step_reg;
            end
            else
            begin
                qout_next[c] = qstep_reg[c];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        step_reg  <= step_pair.step;
        recip_reg <= step_pair.recip;
        lvm1_reg  <= lv_eff - 8'd1;
        top_reg   <= top_prod[PIX_W-1:0];

        if (cmd.accept)
        begin
            v_reg <= pix_in;
            x_reg <= x_norm;
            y_reg <= y_norm;
        end
        else if (add_en)
        begin
            for (int c = 0; c < NCH; c++)
            begin
                v_reg[c] <= add_part(v_reg[c], $signed(add_word[ERR_W*c +: ERR_W]), add_wt);
            end
        end

        for (int c = 0; c < NCH; c++)
        begin
            if (cmd.mul1)
            begin
                q_reg[c] <= recip_prod[c][23:16];
            end
            if (cmd.mul2)
            begin
                qstep_reg[c] <= qstep_prod[c][PIX_W-1:0];
                qtop_reg[c]  <= (q_reg[c] >= lvm1_reg);
            end
            if (cmd.quant)
            begin
                qout_reg[c] <= qout_next[c];
                err_reg[c]  <= {1'b0, v_reg[c]} - {1'b0, qout_next[c]};
            end
        end

        if (cmd.commit)
        begin
            pix_out_reg   <= qout_reg;
            frame_end_reg <= (x_reg == w_eff - CW'(1)) && (y_reg == h_eff - ROW_W'(1));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            levels_reg    <= LEVELS_RESET;
            width_reg     <= WIDTH_RESET;
            height_reg    <= HEIGHT_RESET;
            col_reg       <= '0;
            row_reg       <= '0;
            left_reg      <= '0;
            ul_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_LEVELS: levels_reg <= cfg_data[PIX_W-1:0];
                    CFG_WIDTH:  width_reg  <= cfg_data;
                    CFG_HEIGHT: height_reg <= cfg_data;
                    default:    ;
                endcase
            end

            if (cmd.commit)
            begin
                out_valid_reg <= 1'b1;
                left_reg      <= err_reg;
                ul_reg        <= rdata_a;
                if (x_inc >= w_eff)
                begin
                    col_reg <= '0;
                    row_reg <= (y_inc >= h_eff) ? '0 : y_inc;
                end
                else
                begin
                    col_reg <= x_inc;
                    row_reg <= y_reg;
                end
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // The previous row's errors, blue in the top field and red in the bottom.
    edd_ram #(
        .WIDTH (ERR_PACK_W),
        .DEPTH (MAX_WIDTH)
    ) u_row_store (
        .clk     (clk),
        .we      (cmd.commit),
        .waddr   (x_reg[AW-1:0]),
        .wdata   (err_reg),
        .re      (cmd.accept),
        .raddr_a (x_norm[AW-1:0]),
        .raddr_b (AW'(x_norm + CW'(1))),
        .rdata_a (rdata_a),
        .rdata_b (rdata_b)
    );

    assign sts.out_free = !out_valid_reg || out_ready;
    assign out_valid    = out_valid_reg;
    assign pix_out      = pix_out_reg;
    assign frame_end    = frame_end_reg;

    a_commit_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |-> sts.out_free)
        else $error("result committed over an untaken result");

    a_valid_from_commit: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(cmd.commit))
        else $error("output valid rose without a commit");

    a_left_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !cmd.commit |=> $stable(left_reg))
        else $error("left error changed outside write back");

endmodule

[hw/rtl/error_diffusion_dither_unit.sv]
// An input transfer gives a result registered in write back once the sequencer has walked
// the pixel through four error additions, two multiply stages, the quantizer and write back;
// no new pixel is accepted until the sequencer has returned to idle after write back.
// A stalled output holds the block in write back until the result is taken.
// Reset: raster position and carried errors clear, levels/width/height go to 4/640/480;
// the row error store is not cleared and needs no clearing pass.

module error_diffusion_dither_unit import edd_pkg::*; #(
    parameter int MAX_WIDTH = 4096
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [PIX_W-1:0]      red_in,
    input  logic [PIX_W-1:0]      green_in,
    input  logic [PIX_W-1:0]      blue_in,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [PIX_W-1:0]      red_out,
    output logic [PIX_W-1:0]      green_out,
    output logic [PIX_W-1:0]      blue_out,
    output logic                  frame_end
);

    edd_cmd_t                  cmd;
    edd_sts_t                  sts;
    logic [NCH-1:0][PIX_W-1:0] pix_in;
    logic [NCH-1:0][PIX_W-1:0] pix_out;

    assign pix_in = {blue_in, green_in, red_in};

    edd_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    edd_datapath #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .pix_in    (pix_in),
        .out_ready (out_ready),
        .cmd       (cmd),
        .sts       (sts),
        .out_valid (out_valid),
        .pix_out   (pix_out),
        .frame_end (frame_end)
    );

    assign red_out   = pix_out[0];
    assign green_out = pix_out[1];
    assign blue_out  = pix_out[2];

endmodule
